// File: rtl/dcst_pkg.sv
// ----------------------------------------------------------------------------
// dcst_pkg
// Shared types, codes and helpers of the deadline countdown scheduler.
// ----------------------------------------------------------------------------
package dcst_pkg;

  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 40;
  localparam int TIME_W   = 16;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    TS_DORMANT = 2'd0,
    TS_READY   = 2'd1,
    TS_RUNNING = 2'd2,
    TS_BLOCKED = 2'd3
  } task_state_t;

  typedef struct packed {
    task_state_t       state;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] remaining;
  } task_entry_t;

  // 0 or 1 reloads from the period, otherwise step down by one
  function automatic logic [TIME_W-1:0] count_down(input logic [TIME_W-1:0] rem,
                                                   input logic [TIME_W-1:0] period);
    return (rem <= TIME_W'(1)) ? period : rem - TIME_W'(1);
  endfunction

endpackage

// File: rtl/dcst_cell.sv
// ----------------------------------------------------------------------------
// dcst_cell
// One task entry of the table; shifts toward the head or loads directly.
// ----------------------------------------------------------------------------
module dcst_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift_en,
  input  dcst_pkg::task_entry_t shift_in,
  input  logic                 load_en,
  input  dcst_pkg::task_entry_t load_data,
  output dcst_pkg::task_entry_t q
);
  import dcst_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '{state: TS_DORMANT, period: '0, remaining: '0};
    end else if (shift_en) begin
      q <= shift_in;
    end else if (load_en) begin
      q <= load_data;
    end
  end

endmodule

// File: rtl/dcst_update.sv
// ----------------------------------------------------------------------------
// dcst_update
// Tick update of the entry leaving the head of the chain, plus the
// earlier-deadline compare against the running task.
// ----------------------------------------------------------------------------
module dcst_update #(
  parameter int IDX_W = 4
) (
  input  dcst_pkg::task_entry_t                  entry_in,
  input  logic [IDX_W-1:0]                       k,
  input  logic [IDX_W-1:0]                       cur,
  input  logic [dcst_pkg::TIME_W-1:0]            cur_rem,
  output dcst_pkg::task_entry_t                  entry_out,
  output logic                                   hit
);
  import dcst_pkg::*;

  always_comb begin
    entry_out = entry_in;
    hit       = 1'b0;
    if (k != '0) begin
      if (k == cur) begin
        entry_out.remaining = cur_rem;
      end else if (entry_in.state != TS_DORMANT) begin
        entry_out.remaining = count_down(entry_in.remaining, entry_in.period);
        if (entry_in.remaining <= TIME_W'(1)) begin
          entry_out.state = TS_READY;
        end
      end
      hit = (entry_out.state == TS_READY) && (entry_out.remaining < cur_rem);
    end
  end

endmodule

// File: rtl/deadline_countdown_scheduler_tick_core.sv
// ----------------------------------------------------------------------------
// deadline_countdown_scheduler_tick_core
// Earliest-deadline style task table with a countdown tick.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tuser is the item kind (tick, write entry, read entry).
// Each accepted transfer yields exactly one transfer on m_*.
// Write and read items need no walk: the result is registered at the
// accept edge. A tick walks the table through a ring of TASK_COUNT cells,
// one entry per cycle through a single update unit at the head, then takes
// a done step (ST_DONE) to mark the running task ready on preemption and
// register the result.
// Disabled ticks, out-of-range indexes and the unused kind return zeros at
// once. Items are taken one at a time; a new item is accepted while the last
// result is being taken. While m_tready is low the result holds and s_tready
// stays low. cfg_wen writes scheduler_enable, no read-back.
// rst (synchronous) clears the table to dormant/zero, disables the scheduler
// and drops m_tvalid.
// ----------------------------------------------------------------------------
module deadline_countdown_scheduler_tick_core #(
  parameter int TASK_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // run_task[3:0], task_index[7:4], task_state_in[9:8],
  // period_in[25:10], remaining_in[41:26], zero pad
  input  logic [dcst_pkg::S_DATA_W-1:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // preempt[0], task_state_out[2:1], period_out[18:3],
  // remaining_out[34:19], zero pad
  output logic [dcst_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                          cfg_wen,
  input  logic                          cfg_wdata
);
  import dcst_pkg::*;

  localparam int IDX_W = $clog2(TASK_COUNT);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TASK_COUNT - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} fsm_t;

  fsm_t                state;
  logic                scheduler_enable;
  logic [IDX_W-1:0]    step;
  logic [IDX_W-1:0]    cur;
  logic [TIME_W-1:0]   cur_rem;
  logic                hit;

  task_entry_t         cells_q [TASK_COUNT];
  task_entry_t         tail_in;
  logic                step_hit;
  logic                shift_en;
  logic                load_valid;
  logic [IDX_W-1:0]    load_idx;
  task_entry_t         load_data;

  logic                accept;
  logic [3:0]          in_cur;
  logic [3:0]          in_idx;
  logic                cur_ok;
  logic                idx_ok;
  logic [IDX_W-1:0]    in_cur_i;
  logic [IDX_W-1:0]    in_idx_i;
  task_entry_t         cur_entry;
  task_entry_t         idx_entry;
  task_entry_t         done_entry;
  logic [TIME_W-1:0]   cur_rem_next;

  assign in_cur   = s_tdata[3:0];
  assign in_idx   = s_tdata[7:4];
  assign cur_ok   = int'(in_cur) < TASK_COUNT;
  assign idx_ok   = int'(in_idx) < TASK_COUNT;
  assign in_cur_i = IDX_W'(in_cur);
  assign in_idx_i = IDX_W'(in_idx);

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign shift_en = (state == ST_RUN);

  always_comb begin
    cur_entry  = '{state: TS_DORMANT, period: '0, remaining: '0};
    idx_entry  = '{state: TS_DORMANT, period: '0, remaining: '0};
    if (cur_ok) cur_entry = cells_q[in_cur_i];
    if (idx_ok) idx_entry = cells_q[in_idx_i];
    done_entry       = cells_q[cur];
    done_entry.state = TS_READY;
  end

  assign cur_rem_next = (in_cur == 4'd0) ? cur_entry.remaining
                      : count_down(cur_entry.remaining, cur_entry.period);

  always_comb begin
    load_valid = 1'b0;
    load_idx   = in_idx_i;
    load_data  = '{state:     task_state_t'(s_tdata[9:8]),
                   period:    s_tdata[25:10],
                   remaining: s_tdata[41:26]};
    if (state == ST_IDLE) begin
      load_valid = accept && (mode_t'(s_tuser) == MODE_WRITE) && idx_ok;
    end else if (state == ST_DONE) begin
      load_valid = hit;
      load_idx   = cur;
      load_data  = done_entry;
    end
  end

  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    task_entry_t sin;
    if (i == TASK_COUNT - 1) begin : g_tail
      assign sin = tail_in;
    end else begin : g_mid
      assign sin = cells_q[i+1];
    end
    dcst_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift_en  (shift_en),
      .shift_in  (sin),
      .load_en   (load_valid && (load_idx == IDX_W'(i))),
      .load_data (load_data),
      .q         (cells_q[i])
    );
  end

  dcst_update #(.IDX_W(IDX_W)) u_update (
    .entry_in  (cells_q[0]),
    .k         (step),
    .cur       (cur),
    .cur_rem   (cur_rem),
    .entry_out (tail_in),
    .hit       (step_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      m_tvalid         <= 1'b0;
      scheduler_enable <= 1'b0;
      step             <= '0;
      hit              <= 1'b0;
    end else begin
      if (cfg_wen) scheduler_enable <= cfg_wdata;
      case (state)
        ST_IDLE: begin
          if (m_tvalid && m_tready) m_tvalid <= 1'b0;
          if (accept) begin
            case (mode_t'(s_tuser))
              MODE_TICK: begin
                if (scheduler_enable && cur_ok) begin
                  state   <= ST_RUN;
                  step    <= '0;
                  hit     <= 1'b0;
                  cur     <= in_cur_i;
                  cur_rem <= cur_rem_next;
                end else begin
                  m_tvalid <= 1'b1;
                  m_tdata  <= '0;
                end
              end
              MODE_READ: begin
                m_tvalid <= 1'b1;
                m_tdata  <= M_DATA_W'({idx_entry.remaining, idx_entry.period,
                                       idx_entry.state, 1'b0});
              end
              default: begin
                m_tvalid <= 1'b1;
                m_tdata  <= '0;
              end
            endcase
          end
        end
        ST_RUN: begin
          step <= step + IDX_W'(1);
          hit  <= hit | step_hit;
          if (step == LAST_STEP) state <= ST_DONE;
        end
        ST_DONE: begin
          m_tvalid <= 1'b1;
          m_tdata  <= M_DATA_W'(hit);
          state    <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/dcst_checker.sv
// ----------------------------------------------------------------------------
// dcst_checker
// Port-level checks of the scheduler core, bound to the top level.
// ----------------------------------------------------------------------------
module dcst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [1:0]                    s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [dcst_pkg::M_DATA_W-1:0] m_tdata
);
  import dcst_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && m_tvalid) |-> m_tready)
    else $error("input taken while a result is stalled");

  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == MODE_WRITE) |=> (m_tvalid && m_tdata == '0))
    else $error("write transfer must return an all-zero result next cycle");

  a_read_no_preempt: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == MODE_READ) |=> (m_tvalid && !m_tdata[0]))
    else $error("read result carries preempt");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind deadline_countdown_scheduler_tick_core dcst_checker u_dcst_checker (.*);
